// ----- src/bhpq_pkg.sv -----
// bhpq_pkg: shared widths, constants and the key ordering function
// for the binary heap priority queue; no dependencies
`default_nettype none

package bhpq_pkg;

    localparam int KEY_W        = 32;
    localparam int CAPACITY_DEF = 1024;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic ORDER_MAX_FIRST = 1'b0;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ORDER_MODE = 1'b0;

    localparam logic signed [KEY_W-1:0] KEY_NONE = -32'sd1;

    typedef logic signed [KEY_W-1:0] key_t;

    // strict "a sits above b" under the selected ordering
    function automatic logic ranks_above(input logic mode, input key_t a, input key_t b);
        logic res;
        if (mode == ORDER_MAX_FIRST)
        begin
            res = (a > b);
        end
        else
        begin
            res = (a < b);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/bhpq_heap_ram.sv -----
// bhpq_heap_ram: key store with one write port and two registered read ports
// depends on bhpq_pkg for the key type
`default_nettype none

module bhpq_heap_ram #(
    parameter int DEPTH = bhpq_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire bhpq_pkg::key_t    wr_data,
    input  wire logic [AW-1:0]     rd_a_addr,
    input  wire logic [AW-1:0]     rd_b_addr,
    output bhpq_pkg::key_t         rd_a_data,
    output bhpq_pkg::key_t         rd_b_data
);

    bhpq_pkg::key_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

// ----- src/binary_heap_priority_queue_core.sv -----
// binary_heap_priority_queue_core: top level of the heap priority queue
// depends on bhpq_pkg and bhpq_heap_ram
//
// usage: a request on the input channel (func, key_value) is either a push
// or a pop. push stores the key and sifts it up; pop removes the top key,
// moves the last key to the root and sifts it down. each request gives one
// result with the popped key, the empty and full flags, the new top key
// and the key count. order_mode (apb register at address 0) picks largest
// or smallest key on top; write it only while the block is idle.
// steps: a push opens a hole in the new last slot and, per level climbed,
// reads the parent and compares, moving the parent down into the hole; a
// pop reads the last key into the root hole and, per level descended, reads
// both children and compares, moving the better child up. the key is written
// where it stops. a pop on an empty heap or a push on a full heap goes
// straight to the done state. one request is in flight at a time; the next is taken
// as soon as the previous result sits in the output register, even if the
// receiver has not taken it yet. while the receiver stalls, a finished
// result waits in its final state until the output register frees.
// reset empties the heap and selects largest-first order; the key store
// itself needs no clearing because entries past the count are never read.
`default_nettype none

module binary_heap_priority_queue_core #(
    parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            func,
    input  wire logic signed [bhpq_pkg::KEY_W-1:0] key_value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [bhpq_pkg::KEY_W-1:0]    popped_value,
    output logic                                 was_empty,
    output logic                                 was_full,
    output logic signed [bhpq_pkg::KEY_W-1:0]    top_value,
    output logic [CW-1:0]                        entry_count,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bhpq_pkg::APB_AW-1:0]     paddr,
    input  wire logic [bhpq_pkg::APB_DW-1:0]     pwdata,
    output logic [bhpq_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UP_CHK   = 3'd1;
    localparam logic [2:0] S_UP_CMP   = 3'd2;
    localparam logic [2:0] S_POP_LAST = 3'd3;
    localparam logic [2:0] S_DN_CHK   = 3'd4;
    localparam logic [2:0] S_DN_CMP   = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    localparam logic [CW-1:0] ONE_IDX  = CW'(1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;
    bhpq_pkg::key_t  key_reg, key_next;
    bhpq_pkg::key_t  top_reg, top_next;
    bhpq_pkg::key_t  popped_reg, popped_next;
    logic            empty_reg, empty_next;
    logic            full_reg, full_next;
    logic            order_mode_reg;

    logic            out_valid_reg, out_valid_next;
    bhpq_pkg::key_t  out_popped_reg, out_popped_next;
    logic            out_empty_reg, out_empty_next;
    logic            out_full_reg, out_full_next;
    bhpq_pkg::key_t  out_top_reg, out_top_next;
    logic [CW-1:0]   out_count_reg, out_count_next;

    logic            wr_en;
    logic [CW-1:0]   wr_idx;
    bhpq_pkg::key_t  wr_data;
    logic [CW-1:0]   rd_a_idx, rd_b_idx;
    bhpq_pkg::key_t  rd_a_data, rd_b_data;
    logic [CW-1:0]   wr_off, rd_a_off, rd_b_off;

    logic [CW:0]     left_wide, right_wide;
    logic            has_left, has_right;
    logic            pick_right, left_beats, right_beats, best_beats;
    bhpq_pkg::key_t  best_key;
    logic [CW-1:0]   best_idx;
    logic            cfg_wr;

    assign wr_off   = wr_idx - ONE_IDX;
    assign rd_a_off = rd_a_idx - ONE_IDX;
    assign rd_b_off = rd_b_idx - ONE_IDX;

    bhpq_heap_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_off[AW-1:0]),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_off[AW-1:0]),
        .rd_b_addr (rd_b_off[AW-1:0]),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // children of the current position
    assign left_wide  = {pos_reg, 1'b0};
    assign right_wide = {pos_reg, 1'b1};
    assign has_left   = (left_wide <= {1'b0, count_reg});
    assign has_right  = (right_wide <= {1'b0, count_reg});

    assign pick_right  = has_right
                         && bhpq_pkg::ranks_above(order_mode_reg, rd_b_data, rd_a_data);
    assign left_beats  = bhpq_pkg::ranks_above(order_mode_reg, rd_a_data, key_reg);
    assign right_beats = bhpq_pkg::ranks_above(order_mode_reg, rd_b_data, key_reg);
    assign best_beats  = pick_right ? right_beats : left_beats;
    assign best_key    = pick_right ? rd_b_data : rd_a_data;
    assign best_idx    = pick_right ? right_wide[CW-1:0] : left_wide[CW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        top_next        = top_reg;
        popped_next     = popped_reg;
        empty_next      = empty_reg;
        full_next       = full_reg;
        out_valid_next  = out_valid_reg;
        out_popped_next = out_popped_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        out_top_next    = out_top_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_idx          = pos_reg;
        wr_data         = key_reg;
        rd_a_idx        = pos_reg;
        rd_b_idx        = pos_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    popped_next = bhpq_pkg::KEY_NONE;
                    empty_next  = 1'b0;
                    full_next   = 1'b0;
                    if (func == bhpq_pkg::FUNC_PUSH)
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            full_next  = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + ONE_IDX;
                            pos_next   = count_reg + ONE_IDX;
                            key_next   = key_value;
                            state_next = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            popped_next = top_reg;
                            rd_a_idx    = count_reg;
                            count_next  = count_reg - ONE_IDX;
                            state_next  = S_POP_LAST;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (pos_reg == ONE_IDX)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_a_idx   = pos_reg >> 1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (bhpq_pkg::ranks_above(order_mode_reg, key_reg, rd_a_data))
                begin
                    // parent moves down into the hole
                    wr_data    = rd_a_data;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_LAST:
            begin
                key_next   = rd_a_data;
                pos_next   = ONE_IDX;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (!has_left)
                begin
                    wr_en      = (count_reg != '0);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_a_idx   = left_wide[CW-1:0];
                    rd_b_idx   = has_right ? right_wide[CW-1:0] : left_wide[CW-1:0];
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (best_beats)
                begin
                    // better child moves up into the hole
                    wr_data    = best_key;
                    pos_next   = best_idx;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_popped_next = popped_reg;
                    out_empty_next  = empty_reg;
                    out_full_next   = full_reg;
                    out_top_next    = (count_reg == '0) ? bhpq_pkg::KEY_NONE : top_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en && (wr_idx == ONE_IDX))
        begin
            top_next = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        top_reg        <= top_next;
        popped_reg     <= popped_next;
        empty_reg      <= empty_next;
        full_reg       <= full_next;
        out_popped_reg <= out_popped_next;
        out_empty_reg  <= out_empty_next;
        out_full_reg   <= out_full_next;
        out_top_reg    <= out_top_next;
        out_count_reg  <= out_count_next;
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[bhpq_pkg::APB_AW-1] == bhpq_pkg::REG_ORDER_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= bhpq_pkg::ORDER_MAX_FIRST;
        end
        else if (cfg_wr)
        begin
            order_mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[bhpq_pkg::APB_AW-1] == bhpq_pkg::REG_ORDER_MODE)
                    ? {{(bhpq_pkg::APB_DW-1){1'b0}}, order_mode_reg}
                    : '0;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign was_empty    = out_empty_reg;
    assign was_full     = out_full_reg;
    assign top_value    = out_top_reg;
    assign entry_count  = out_count_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("key count above capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_idx >= ONE_IDX) && (wr_idx <= count_reg))
        else $error("key store write outside the held entries");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_empty && was_full))
        else $error("empty and full flags both set");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> ($stable(count_reg) || (state_reg != S_IDLE)))
        else $error("key count changed outside a request");

endmodule

`default_nettype wire
